// File: hdl/psdf_pkg.sv
// Shared types and sizing constants for the per-source duplicate frame filter.
// No dependencies; imported by the controller, the datapath and the top level.
package psdf_pkg;

  localparam int SOURCES     = 16;
  localparam int DEPTH       = 8;

  localparam int SRC_W       = 5;
  localparam int SEQ_W       = 12;
  localparam int NODE_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STORE_DEPTH = SOURCES * DEPTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_WRITE,
    ST_DONE
  } psdf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input beat
    logic scan;   // issue one ring read
    logic write;  // store sequence number, advance pointer
    logic emit;   // load result register
  } psdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic src_ok;
    logic retry;
    logic last_issue;
    logic hit;
    logic out_free;
  } psdf_sts_t;

endpackage

// File: hdl/psdf_ctrl.sv
// Sequencing state machine for the duplicate frame filter.
// Depends on psdf_pkg; drives commands into psdf_dpath.
module psdf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psdf_pkg::psdf_sts_t sts,
  output psdf_pkg::psdf_cmd_t cmd
);
  import psdf_pkg::*;

  psdf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (!sts.src_ok) state_nxt = ST_DONE;
        else if (sts.retry)       state_nxt = ST_SCAN;
        else                      state_nxt = ST_WRITE;
      end
      ST_SCAN: begin
        if (sts.last_issue) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        // last slot compares here
        state_nxt = sts.hit ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.scan  = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_DONE:  cmd.emit  = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: hdl/psdf_dpath.sv
// Datapath: sequence store memory with per-entry valid bits, ring pointers,
// scan counter, hit flag and result register. Depends on psdf_pkg.
module psdf_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [psdf_pkg::SRC_W-1:0]        in_source_id,
  input  logic [psdf_pkg::SEQ_W-1:0]        in_sequence_number,
  input  logic                              in_retry_flag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_is_duplicate,
  input  psdf_pkg::psdf_cmd_t               cmd,
  output psdf_pkg::psdf_sts_t               sts
);
  import psdf_pkg::*;

  logic [SEQ_W-1:0]  mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] ent_vld_r;
  logic [PTR_W-1:0]  ptr_r [SOURCES];

  logic [SEQ_W-1:0]  seq_r;
  logic              retry_r;
  logic              src_ok_r;
  logic [NODE_W-1:0] node_r;
  logic [ADDR_W-1:0] base_r;
  logic [PTR_W-1:0]  k_r;
  logic              cmp_vld_r;
  logic              hit_r;
  logic [SEQ_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic              out_valid_r;
  logic              out_dup_r;

  logic              src_ok_nxt;
  logic [NODE_W-1:0] node_nxt;
  logic [ADDR_W-1:0] base_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [PTR_W-1:0]  cur_ptr;
  logic [SEQ_W-1:0]  slot_val;
  logic              match;

  assign src_ok_nxt = (in_source_id != '0) &&
                      ({4'b0, in_source_id} <= 9'(SOURCES));
  assign node_nxt   = NODE_W'(in_source_id - SRC_W'(1));
  assign base_nxt   = ADDR_W'(32'(node_nxt) * DEPTH);

  assign rd_addr  = base_r + ADDR_W'(k_r);
  assign cur_ptr  = ptr_r[node_r];
  assign wr_addr  = base_r + ADDR_W'(cur_ptr);
  // unwritten entries read as zero
  assign slot_val = rd_vld_r ? rd_data_r : '0;
  assign match    = cmp_vld_r && (slot_val == seq_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r    <= in_sequence_number;
      retry_r  <= in_retry_flag;
      src_ok_r <= src_ok_nxt;
      node_r   <= node_nxt;
      base_r   <= base_nxt;
    end
  end

  // store memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) mem[wr_addr] <= seq_r;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      for (int i = 0; i < SOURCES; i++) ptr_r[i] <= '0;
    end else begin
      rd_vld_r <= ent_vld_r[rd_addr];
      if (cmd.write) begin
        ent_vld_r[wr_addr] <= 1'b1;
        ptr_r[node_r] <= (cur_ptr == PTR_W'(DEPTH - 1)) ? '0 : cur_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.load) begin
        k_r   <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.scan) k_r <= k_r + PTR_W'(1);
        if (match) hit_r <= 1'b1;
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_dup_r <= hit_r;
  end

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  assign sts.src_ok     = src_ok_r;
  assign sts.retry      = retry_r;
  assign sts.last_issue = (k_r == PTR_W'(DEPTH - 1));
  assign sts.hit        = hit_r | match;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// File: hdl/per_source_duplicate_frame_filter.sv
// Channel | Ports                                                 | Direction
// in      | in_valid, in_stall, in_source_id, in_sequence_number, | in (stall out)
//         | in_retry_flag                                         |
// out     | out_valid, out_stall, out_is_duplicate                | out (stall in)
//
// One beat at a time. A retried frame with a valid source scans the ring memory,
// one read per cycle, then stores its number on a miss; a hit skips the store.
// Other frames skip the scan; a bad source number skips the store as well.
// One result per beat. A finished result sits in the output register while the
// next beat is taken; a stalled result holds the following one back until taken.
// Reset (rst_n low, synchronous) clears pointers and entry valid bits at once.
// Top level: depends on psdf_pkg, psdf_ctrl and psdf_dpath.
module per_source_duplicate_frame_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [psdf_pkg::SRC_W-1:0] in_source_id,
  input  logic [psdf_pkg::SEQ_W-1:0] in_sequence_number,
  input  logic                       in_retry_flag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_is_duplicate
);
  import psdf_pkg::*;

  psdf_cmd_t cmd;
  psdf_sts_t sts;

  psdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psdf_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_source_id       (in_source_id),
    .in_sequence_number (in_sequence_number),
    .in_retry_flag      (in_retry_flag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_duplicate   (out_is_duplicate),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// File: tb/dup_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the per-source duplicate frame filter: watches both channels, keeps its own
// copy of the sequence rings and compares each result beat. Depends on psdf_pkg.
module dup_filter_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [psdf_pkg::SRC_W-1:0] in_source_id,
  input  logic [psdf_pkg::SEQ_W-1:0] in_sequence_number,
  input  logic                       in_retry_flag,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_is_duplicate,
  output int                         mismatch_count,
  output int                         frames_in_flight
);
  import psdf_pkg::*;

  typedef struct {
    logic [SRC_W-1:0] source;
    logic [SEQ_W-1:0] seq;
    logic             retry;
    logic             dup;
  } frame_verdict_t;

  logic [SEQ_W-1:0] seen_seq [SOURCES][DEPTH];
  int               oldest_slot [SOURCES];
  frame_verdict_t   expected_verdicts [$];

  initial begin
    mismatch_count   = 0;
    frames_in_flight = 0;
  end

  // Updates the rings as the block would and returns the drop decision.
  function automatic logic predict_duplicate(logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq,
                                             logic retry);
    int node;
    logic hit;
    hit = 1'b0;
    if (src == 0 || src > SOURCES) return 1'b0;
    node = src - 1;
    if (retry) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (seen_seq[node][k] == seq) hit = 1'b1;
      end
    end
    if (hit) return 1'b1;
    seen_seq[node][oldest_slot[node]] = seq;
    oldest_slot[node] = (oldest_slot[node] + 1 >= DEPTH) ? 0 : oldest_slot[node] + 1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    frame_verdict_t fv;
    if (!rst_n) begin
      for (int n = 0; n < SOURCES; n++) begin
        oldest_slot[n] = 0;
        for (int k = 0; k < DEPTH; k++) seen_seq[n][k] = '0;
      end
      expected_verdicts.delete();
    end else begin
      // retire first: a result beat never belongs to the frame taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("ERROR: result beat with no frame outstanding, is_duplicate %0b",
                     out_is_duplicate);
        end else begin
          fv = expected_verdicts.pop_front();
          if (out_is_duplicate !== fv.dup) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("ERROR: src %0d seq %0d retry %0b: is_duplicate expected %0b got %0b",
                       fv.source, fv.seq, fv.retry, fv.dup, out_is_duplicate);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fv.source = in_source_id;
        fv.seq    = in_sequence_number;
        fv.retry  = in_retry_flag;
        fv.dup    = predict_duplicate(in_source_id, in_sequence_number, in_retry_flag);
        expected_verdicts.push_back(fv);
      end
    end
    frames_in_flight <= expected_verdicts.size();
  end

endmodule

// File: tb/tb_per_source_duplicate_frame_filter.sv
`timescale 1ns / 100ps
// Top of the duplicate frame filter testbench: clock, reset, frame stimulus and verdict.
// Depends on psdf_pkg, per_source_duplicate_frame_filter and dup_filter_checker.
module tb_per_source_duplicate_frame_filter;
  import psdf_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [SRC_W-1:0] in_source_id;
  logic [SEQ_W-1:0] in_sequence_number;
  logic             in_retry_flag;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_is_duplicate;

  int               mismatch_count;
  int               frames_in_flight;
  int               send_idle_pct;
  int               recv_stall_pct;
  logic [SEQ_W-1:0] window_base [1:SOURCES];

  always #10 clk = ~clk;

  per_source_duplicate_frame_filter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_id       (in_source_id),
    .in_sequence_number (in_sequence_number),
    .in_retry_flag      (in_retry_flag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_duplicate   (out_is_duplicate)
  );

  dup_filter_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_id       (in_source_id),
    .in_sequence_number (in_sequence_number),
    .in_retry_flag      (in_retry_flag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_duplicate   (out_is_duplicate),
    .mismatch_count     (mismatch_count),
    .frames_in_flight   (frames_in_flight)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // valid stays high from one beat to the next unless an idle cycle is drawn
  task automatic send_frame(logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq, logic retry);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_source_id       <= src;
    in_sequence_number <= seq;
    in_retry_flag      <= retry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly frames near a per-source window so retries both hit and miss the ring;
  // the rest carry a source number that selects no ring.
  task automatic send_random_frame();
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] seq;
    logic             retry;
    if ($urandom_range(0, 99) < 10) begin
      src   = $urandom_range(0, 1) ? '0 : SRC_W'($urandom_range(SOURCES + 1, 31));
      seq   = SEQ_W'($urandom);
      retry = 1'($urandom);
    end else begin
      src = SRC_W'($urandom_range(1, SOURCES));
      if ($urandom_range(0, 19) == 0) window_base[src] = SEQ_W'($urandom);
      seq   = window_base[src] + SEQ_W'($urandom_range(0, 11));
      retry = ($urandom_range(0, 99) < 45);
    end
    send_frame(src, seq, retry);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(posedge clk);
    while (frames_in_flight != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    int phase_idle [3];
    int phase_stall [3];
    phase_idle  = '{19, 76, 0};
    phase_stall = '{76, 19, 0};
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_source_id       <= '0;
    in_sequence_number <= '0;
    in_retry_flag      <= 1'b0;
    send_idle_pct  = phase_idle[0];
    recv_stall_pct = phase_stall[0];
    for (int n = 1; n <= SOURCES; n++) window_base[n] = SEQ_W'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // untouched ring is all zero, so a retried zero already counts as seen
    send_frame(5'd1, 12'd0, 1'b1);
    send_frame(5'd16, 12'd4095, 1'b1);
    send_frame(5'd16, 12'd4095, 1'b1);
    send_frame(5'd16, 12'd4095, 1'b0);  // not retried: stored again
    send_frame(5'd0, 12'd0, 1'b1);
    send_frame(5'd17, 12'd4095, 1'b1);
    send_frame(5'd31, 12'd2730, 1'b0);
    // nine fresh numbers wrap the ring and evict the first one
    for (int k = 0; k < 9; k++) send_frame(5'd2, SEQ_W'(100 + k), 1'b0);
    send_frame(5'd2, 12'd100, 1'b1);
    send_frame(5'd2, 12'd108, 1'b1);
    send_frame(5'd2, 12'd0, 1'b1);
    send_frame(5'd3, 12'd1365, 1'b1);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 145; i++) send_random_frame();
      // hold the sender off until the filter has answered everything
      in_valid <= 1'b0;
      drain_results();
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && frames_in_flight == 0) begin
      $display("per_source_duplicate_frame_filter regression: pass");
    end else begin
      $display("per_source_duplicate_frame_filter regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("per_source_duplicate_frame_filter regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/psdf_pkg.sv
hdl/psdf_ctrl.sv
hdl/psdf_dpath.sv
hdl/per_source_duplicate_frame_filter.sv
tb/dup_filter_checker.sv
tb/tb_per_source_duplicate_frame_filter.sv
